@@ rtl/su2f_pkg.sv @@
// Shared constants, types and state codes for the level-k SU(2) fusion engine.
// No dependencies; every other file of the block imports this package.
package su2f_pkg;

  localparam int MAX_LEVEL   = 31;
  localparam int DEPTH       = MAX_LEVEL + 1;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CALC_W      = ADDR_W + 2;
  localparam int LEVEL_W     = 5;
  localparam int LABEL_W     = 5;
  localparam int INDEX_W     = 5;
  localparam int COUNT_W     = 63;
  localparam int LEVEL_RESET = 31;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam count_t COUNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_X,
    ST_GET_X,
    ST_ADD_Y,
    ST_SWAP,
    ST_EM_RD,
    ST_EM_OUT
  } su2f_state_e;

  // Requests from the sequencer to the count store.
  typedef struct packed {
    logic   cur_re;
    addr_t  cur_addr;
    logic   nxt_re;
    addr_t  nxt_addr;
    logic   nxt_we;
    addr_t  nxt_waddr;
    count_t nxt_wdata;
    logic   clr_nxt;
    logic   swap;
    logic   unit;
  } mem_req_t;

endpackage

@@ rtl/su2f_if.sv @@
// Valid/ready channel interfaces for label items and multiplicity result items.
// Depends on su2f_pkg for field widths.
interface su2f_in_if import su2f_pkg::*;;
  logic               valid;
  logic               ready;
  logic [LABEL_W-1:0] label;
  logic               final_label;

  modport source (output valid, label, final_label, input ready);
  modport sink (input valid, label, final_label, output ready);
endinterface

interface su2f_out_if import su2f_pkg::*;;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] out_index;
  count_t             multiplicity;
  logic               saturated;
  logic               last;

  modport source (output valid, out_index, multiplicity, saturated, last, input ready);
  modport sink (input valid, out_index, multiplicity, saturated, last, output ready);
endinterface

@@ rtl/su2_level_fusion_multiplicity.sv @@
// Level-k SU(2) fusion multiplicity engine: level register, sequencer and count store.
// Depends on su2f_pkg, su2f_if, su2f_store and su2f_ctrl.
//
// Each label item replaces the multiplicity vector over labels 0..k by its fusion
// product with that label. An item is accepted, every entry x in 0..k is read and
// added to each output entry it hits (none when its count is zero), and the banks
// swap; the next vector lives in one single-port-write bank updated one entry per
// cycle. An item marked final then streams k+1 results, each held under
// back-pressure, and the next item is taken once the last result is in the output
// register. Level writes are taken any time the block is idle.
module su2_level_fusion_multiplicity import su2f_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LEVEL_W-1:0] cfg_wdata_i,
  su2f_in_if.sink            in_if,
  su2f_out_if.source         out_if
);

  logic [LEVEL_W-1:0] level_q;
  mem_req_t           req;
  count_t             cur_rdata, nxt_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LEVEL_W'(LEVEL_RESET);
    end else if (cfg_we_i) begin
      level_q <= cfg_wdata_i;
    end
  end

  su2f_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .level_i     (level_q),
    .in_if       (in_if),
    .out_if      (out_if),
    .req_o       (req),
    .cur_rdata_i (cur_rdata),
    .nxt_rdata_i (nxt_rdata)
  );

  su2f_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .cur_rdata_o (cur_rdata),
    .nxt_rdata_o (nxt_rdata)
  );

endmodule

@@ rtl/su2f_store.sv @@
// Ping-pong count store: two synchronous banks, current and next, swapped per label.
// Valid bits stand in for clearing; a unit flag makes the current bank read as the unit.
module su2f_store import su2f_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output count_t   cur_rdata_o,
  output count_t   nxt_rdata_o
);

  count_t mem0 [DEPTH];
  count_t mem1 [DEPTH];
  count_t rd0_q, rd1_q;

  logic             sel_q;
  logic             unit_q;
  logic [DEPTH-1:0] vld0_q, vld1_q;
  logic             rsel_q;
  logic             cur_unit_q, cur_one_q, cur_vld_q, nxt_vld_q;

  logic  re0, re1, we0, we1;
  addr_t ra0, ra1;

  // Bank sel_q holds the current vector, the other bank the next one.
  always_comb begin
    if (!sel_q) begin
      re0 = req_i.cur_re;
      ra0 = req_i.cur_addr;
      re1 = req_i.nxt_re;
      ra1 = req_i.nxt_addr;
      we0 = 1'b0;
      we1 = req_i.nxt_we;
    end else begin
      re1 = req_i.cur_re;
      ra1 = req_i.cur_addr;
      re0 = req_i.nxt_re;
      ra0 = req_i.nxt_addr;
      we1 = 1'b0;
      we0 = req_i.nxt_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we0) mem0[req_i.nxt_waddr] <= req_i.nxt_wdata;
    if (re0) rd0_q <= mem0[ra0];
  end

  always_ff @(posedge clk_i) begin
    if (we1) mem1[req_i.nxt_waddr] <= req_i.nxt_wdata;
    if (re1) rd1_q <= mem1[ra1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q      <= 1'b0;
      unit_q     <= 1'b1;
      vld0_q     <= '0;
      vld1_q     <= '0;
      rsel_q     <= 1'b0;
      cur_unit_q <= 1'b0;
      cur_one_q  <= 1'b0;
      cur_vld_q  <= 1'b0;
      nxt_vld_q  <= 1'b0;
    end else begin
      if (req_i.clr_nxt) begin
        if (sel_q) vld0_q <= '0;
        else       vld1_q <= '0;
      end
      if (we0) vld0_q[req_i.nxt_waddr] <= 1'b1;
      if (we1) vld1_q[req_i.nxt_waddr] <= 1'b1;
      if (req_i.swap) begin
        sel_q  <= ~sel_q;
        unit_q <= 1'b0;
      end
      if (req_i.unit) unit_q <= 1'b1;
      if (req_i.cur_re || req_i.nxt_re) rsel_q <= sel_q;
      if (req_i.cur_re) begin
        cur_unit_q <= unit_q;
        cur_one_q  <= (req_i.cur_addr == '0);
        cur_vld_q  <= sel_q ? vld1_q[req_i.cur_addr] : vld0_q[req_i.cur_addr];
      end
      if (req_i.nxt_re) begin
        nxt_vld_q <= sel_q ? vld0_q[req_i.nxt_addr] : vld1_q[req_i.nxt_addr];
      end
    end
  end

  always_comb begin
    if (cur_unit_q)     cur_rdata_o = cur_one_q ? COUNT_W'(1) : '0;
    else if (cur_vld_q) cur_rdata_o = rsel_q ? rd1_q : rd0_q;
    else                cur_rdata_o = '0;
    nxt_rdata_o = nxt_vld_q ? (rsel_q ? rd0_q : rd1_q) : '0;
  end

endmodule

@@ rtl/su2f_ctrl.sv @@
// Sequencer: walks the current vector, read-modify-writes the next vector with a
// saturating add, swaps banks and streams the results. Uses su2f_pkg and su2f_if.
module su2f_ctrl import su2f_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [LEVEL_W-1:0] level_i,
  su2f_in_if.sink            in_if,
  su2f_out_if.source         out_if,
  output mem_req_t           req_o,
  input  count_t             cur_rdata_i,
  input  count_t             nxt_rdata_i
);

  su2f_state_e state_q, state_d;

  logic [LABEL_W-1:0] b_q, b_d;
  logic               fin_q, fin_d;
  addr_t              k_q, k_d, x_q, x_d, y_q, y_d, hi_q, hi_d;
  count_t             v_q, v_d;
  logic               ovf_q, ovf_d;
  logic               pv_q, pv_d;
  addr_t              py_q, py_d;

  logic               ov_q, ov_d;
  logic [INDEX_W-1:0] oidx_q, oidx_d;
  count_t             omul_q, omul_d;
  logic               osat_q, osat_d;
  logic               olast_q, olast_d;

  logic [COUNT_W:0]   sum;
  logic [CALC_W-1:0]  xb, twok, lo, hb, hmin, ynext;
  logic               span_ok;
  logic               x_end;
  logic               load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovf_q   <= 1'b0;
      pv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ovf_q   <= ovf_d;
      pv_q    <= pv_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q     <= b_d;
    fin_q   <= fin_d;
    k_q     <= k_d;
    x_q     <= x_d;
    y_q     <= y_d;
    hi_q    <= hi_d;
    v_q     <= v_d;
    py_q    <= py_d;
    oidx_q  <= oidx_d;
    omul_q  <= omul_d;
    osat_q  <= osat_d;
    olast_q <= olast_d;
  end

  // Range of outputs hit by entry x: |x-b| .. min(x+b, 2k-x-b), step two.
  always_comb begin
    xb      = CALC_W'(x_q) + CALC_W'(b_q);
    twok    = CALC_W'(k_q) << 1;
    lo      = (CALC_W'(x_q) > CALC_W'(b_q)) ? CALC_W'(x_q) - CALC_W'(b_q)
                                            : CALC_W'(b_q) - CALC_W'(x_q);
    hb      = twok - xb;
    hmin    = (hb < xb) ? hb : xb;
    span_ok = (twok >= xb) && (hb >= lo);
    ynext   = CALC_W'(y_q) + CALC_W'(2);
    x_end   = (x_q == k_q);
    sum     = {1'b0, nxt_rdata_i} + {1'b0, v_q};
  end

  always_comb begin
    state_d = state_q;
    b_d     = b_q;
    fin_d   = fin_q;
    k_d     = k_q;
    x_d     = x_q;
    y_d     = y_q;
    hi_d    = hi_q;
    v_d     = v_q;
    ovf_d   = ovf_q;
    pv_d    = 1'b0;
    py_d    = py_q;
    ov_d    = ov_q && !out_if.ready;
    oidx_d  = oidx_q;
    omul_d  = omul_q;
    osat_d  = osat_q;
    olast_d = olast_q;
    load    = 1'b0;

    in_if.ready = 1'b0;
    req_o       = '0;

    // Write stage of the next-vector update: saturating add of the read count.
    if (pv_q) begin
      req_o.nxt_we    = 1'b1;
      req_o.nxt_waddr = py_q;
      if (sum[COUNT_W]) begin
        req_o.nxt_wdata = COUNT_MAX;
        ovf_d           = 1'b1;
      end else begin
        req_o.nxt_wdata = sum[COUNT_W-1:0];
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          b_d   = in_if.label;
          fin_d = in_if.final_label;
          if (int'(level_i) > MAX_LEVEL) k_d = ADDR_W'(MAX_LEVEL);
          else                           k_d = ADDR_W'(level_i);
          x_d           = '0;
          req_o.clr_nxt = 1'b1;
          state_d       = ST_RD_X;
        end
      end
      ST_RD_X: begin
        req_o.cur_re   = 1'b1;
        req_o.cur_addr = x_q;
        state_d        = ST_GET_X;
      end
      ST_GET_X: begin
        if (cur_rdata_i != '0 && span_ok) begin
          v_d     = cur_rdata_i;
          y_d     = ADDR_W'(lo);
          hi_d    = ADDR_W'(hmin);
          state_d = ST_ADD_Y;
        end else if (x_end) begin
          state_d = ST_SWAP;
        end else begin
          x_d     = x_q + ADDR_W'(1);
          state_d = ST_RD_X;
        end
      end
      ST_ADD_Y: begin
        req_o.nxt_re   = 1'b1;
        req_o.nxt_addr = y_q;
        pv_d           = 1'b1;
        py_d           = y_q;
        if (ynext > CALC_W'(hi_q)) begin
          if (x_end) begin
            state_d = ST_SWAP;
          end else begin
            x_d     = x_q + ADDR_W'(1);
            state_d = ST_RD_X;
          end
        end else begin
          y_d = ADDR_W'(ynext);
        end
      end
      ST_SWAP: begin
        req_o.swap = 1'b1;
        x_d        = '0;
        state_d    = fin_q ? ST_EM_RD : ST_IDLE;
      end
      ST_EM_RD: begin
        req_o.cur_re   = 1'b1;
        req_o.cur_addr = x_q;
        state_d        = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        // Hold the read data until the output register frees up.
        if (!ov_q || out_if.ready) begin
          load    = 1'b1;
          oidx_d  = INDEX_W'(x_q);
          omul_d  = cur_rdata_i;
          osat_d  = ovf_q;
          olast_d = x_end;
          if (x_end) begin
            req_o.unit = 1'b1;
            ovf_d      = 1'b0;
            state_d    = ST_IDLE;
          end else begin
            x_d     = x_q + ADDR_W'(1);
            state_d = ST_EM_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (load) ov_d = 1'b1;
  end

  assign out_if.valid        = ov_q;
  assign out_if.out_index    = oidx_q;
  assign out_if.multiplicity = omul_q;
  assign out_if.saturated    = osat_q;
  assign out_if.last         = olast_q;

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_o.nxt_re && req_o.nxt_we && req_o.nxt_addr == req_o.nxt_waddr))
    else $error("next-vector read and write hit the same entry");

  a_y_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ADD_Y |-> y_q <= k_q && y_q <= hi_q)
    else $error("output index beyond level");

  a_drained_at_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SWAP |=> !pv_q)
    else $error("update still in flight after bank swap");

  a_sat_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_o.unit |=> !ovf_q && state_q == ST_IDLE)
    else $error("saturation flag survived return to unit");

endmodule
